FILE: design/bpe_pkg.sv
// bezier patch evaluator package: word types and fixed-point constants
// no dependencies
package bpe_pkg;

  localparam int unsigned OpLoad = 0;
  localparam int unsigned OpEval = 1;
  localparam int unsigned ParamBits = 17;
  localparam logic [16:0] OneQ16 = 17'd65536;

  typedef struct packed {
    logic               operation;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [16:0]        u_param;
    logic [16:0]        v_param;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] surface_x;
    logic signed [31:0] surface_y;
    logic signed [31:0] surface_z;
  } out_word_t;

endpackage

FILE: design/bezier_patch_evaluator_core.sv
// bezier patch evaluator top: control grid, row and column reduction chains
// an evaluate's result follows the row read and load states and the level steps of the
// cell chains; the row chain is shared by all rows; one evaluate at a time, and no new
// input is taken until the result is taken; one load per cycle while no evaluate runs
// reset (rst_n, synchronous) clears control state; the grid is undefined until written
// depends on bpe_pkg, bpe_reduce_chain, bpe_lerp_cell
module bezier_patch_evaluator_core #(
  parameter int POINTS_PER_ROW = 4,
  parameter int ROW_COUNT      = 4,
  parameter int COORD_BITS     = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bpe_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bpe_pkg::out_word_t out_data
);
  import bpe_pkg::*;

  localparam int RowW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int ColW = (POINTS_PER_ROW > 1) ? $clog2(POINTS_PER_ROW) : 1;
  localparam int LvlW = $clog2(((POINTS_PER_ROW > ROW_COUNT) ? POINTS_PER_ROW : ROW_COUNT) + 1);
  localparam int PtW  = 3*COORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_ROWRD, S_ROWLD, S_ROWST, S_ROWWT, S_COLST, S_COLWT, S_OUT
  } st_t;

  // grid memory: one row of points per address
  logic [POINTS_PER_ROW*PtW-1:0] grid_mem [ROW_COUNT];
  logic [POINTS_PER_ROW*PtW-1:0] grid_rd_r;

  st_t             st_r;
  logic [RowW-1:0] row_r;
  logic [LvlW-1:0] lvl_r;
  logic [16:0]     u_r, v_r;
  logic            row_load, row_step, col_load, col_step;
  logic [PtW-1:0]  row_res, col_res;
  logic [ROW_COUNT*PtW-1:0] col_pts_r;

  logic accept;
  assign in_ready = (st_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // load writes one point, sign-extended to the coordinate width
  logic [PtW-1:0] wr_pt;
  assign wr_pt = {COORD_BITS'(in_data.point_z), COORD_BITS'(in_data.point_y),
                  COORD_BITS'(in_data.point_x)};
  always_ff @(posedge clk) begin
    if (accept && in_data.operation == 1'(OpLoad)
        && 32'(in_data.row_index) < ROW_COUNT && 32'(in_data.col_index) < POINTS_PER_ROW) begin
      grid_mem[RowW'(in_data.row_index)][ColW'(in_data.col_index)*PtW +: PtW] <= wr_pt;
    end
    grid_rd_r <= grid_mem[row_r];
  end

  assign row_load = (st_r == S_ROWLD);
  assign row_step = (st_r == S_ROWST);
  assign col_load = (st_r == S_ROWWT) && (lvl_r == 0) && (row_r == RowW'(ROW_COUNT-1));
  assign col_step = (st_r == S_COLST);

  bpe_reduce_chain #(.Points(POINTS_PER_ROW), .CoordBits(COORD_BITS)) u_rows (
    .clk(clk), .load(row_load), .step(row_step), .pts_in(grid_rd_r), .t(u_r),
    .result(row_res)
  );

  logic [ROW_COUNT*PtW-1:0] col_in;
  always_comb begin
    col_in = col_pts_r;
    col_in[(ROW_COUNT-1)*PtW +: PtW] = row_res;
  end

  bpe_reduce_chain #(.Points(ROW_COUNT), .CoordBits(COORD_BITS)) u_cols (
    .clk(clk), .load(col_load), .step(col_step), .pts_in(col_in), .t(v_r),
    .result(col_res)
  );

  // sequencer: per row read, load, (step, wait) per level; then column levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
      row_r     <= '0;
      lvl_r     <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (accept && in_data.operation == 1'(OpEval)) begin
            u_r   <= (in_data.u_param > OneQ16) ? OneQ16 : in_data.u_param;
            v_r   <= (in_data.v_param > OneQ16) ? OneQ16 : in_data.v_param;
            row_r <= '0;
            st_r  <= S_ROWRD;
          end
        end
        S_ROWRD: begin
          st_r <= S_ROWLD;
        end
        S_ROWLD: begin
          lvl_r <= LvlW'(POINTS_PER_ROW-1);
          st_r  <= S_ROWST;
        end
        S_ROWST: begin
          lvl_r <= lvl_r - 1'b1;
          st_r  <= S_ROWWT;
        end
        S_ROWWT: begin
          if (lvl_r != 0) begin
            st_r <= S_ROWST;
          end else if (row_r == RowW'(ROW_COUNT-1)) begin
            lvl_r <= LvlW'(ROW_COUNT-1);
            st_r  <= S_COLST;
          end else begin
            col_pts_r[row_r*PtW +: PtW] <= row_res;
            row_r <= row_r + 1'b1;
            st_r  <= S_ROWRD;
          end
        end
        S_COLST: begin
          lvl_r <= lvl_r - 1'b1;
          st_r  <= S_COLWT;
        end
        S_COLWT: begin
          if (lvl_r != 0) begin
            st_r <= S_COLST;
          end else begin
            out_data.surface_x <= 32'(signed'(col_res[0 +: COORD_BITS]));
            out_data.surface_y <= 32'(signed'(col_res[COORD_BITS +: COORD_BITS]));
            out_data.surface_z <= 32'(signed'(col_res[2*COORD_BITS +: COORD_BITS]));
            out_valid <= 1'b1;
            st_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            st_r      <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/bpe_lerp_cell.sv
// one interpolation cell: registers asr((1-t)*a,16)+asr(t*b,16) for one coordinate
// depends on bpe_pkg
module bpe_lerp_cell #(
  parameter int CoordBits = 32
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [CoordBits-1:0] a,
  input  logic signed [CoordBits-1:0] b,
  input  logic [16:0]                 t,
  output logic signed [CoordBits-1:0] p_r
);
  import bpe_pkg::*;

  logic signed [17:0]             t_s, tc_s;
  logic signed [CoordBits+17:0]   pa, pb;
  logic signed [CoordBits+17:0]   sum;
  logic signed [CoordBits-1:0]    p_nxt;

  // two products, each truncated toward minus infinity
  always_comb begin
    t_s   = signed'({1'b0, t});
    tc_s  = signed'({1'b0, OneQ16 - t});
    pa    = tc_s * a;
    pb    = t_s * b;
    sum   = (pa >>> 16) + (pb >>> 16);
    p_nxt = sum[CoordBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) p_r <= p_nxt;
  end
endmodule

FILE: design/bpe_reduce_chain.sv
// chain of lerp cells: one de Casteljau level per step over n points of 3 coords
// depends on bpe_pkg, bpe_lerp_cell
module bpe_reduce_chain #(
  parameter int Points    = 4,
  parameter int CoordBits = 32
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [Points*3*CoordBits-1:0] pts_in,
  input  logic [16:0]                 t,
  output logic [3*CoordBits-1:0]      result
);
  import bpe_pkg::*;

  logic signed [CoordBits-1:0] pt_r [Points][3];
  logic signed [CoordBits-1:0] cell_q [Points-1][3];

  // each cell combines its point with its right neighbor
  for (genvar i = 0; i < Points-1; i++) begin : g_cell
    for (genvar c = 0; c < 3; c++) begin : g_crd
      bpe_lerp_cell #(.CoordBits(CoordBits)) u_cell (
        .clk(clk), .en(step), .a(pt_r[i][c]), .b(pt_r[i+1][c]), .t(t),
        .p_r(cell_q[i][c])
      );
    end
  end

  // point registers take the new words or the cell outputs after a step
  logic step_d_r;
  always_ff @(posedge clk) begin
    step_d_r <= step;
    if (load) begin
      for (int i = 0; i < Points; i++) begin
        for (int c = 0; c < 3; c++) begin
          pt_r[i][c] <= pts_in[(i*3+c)*CoordBits +: CoordBits];
        end
      end
    end else if (step_d_r) begin
      for (int i = 0; i < Points-1; i++) begin
        for (int c = 0; c < 3; c++) begin
          pt_r[i][c] <= cell_q[i][c];
        end
      end
    end
  end

  // the first cell holds the reduced point right after the last step
  assign result = {cell_q[0][2], cell_q[0][1], cell_q[0][0]};
endmodule
